@@ rtl/esc_pkg.sv @@
// Shared constants and types for the environmental sensor compensation unit.
// No dependencies; compile first.
package esc_pkg;

	localparam int RAW_P_W   = 20;
	localparam int RAW_T_W   = 20;
	localparam int RAW_H_W   = 16;
	localparam int TEMP_W    = 16;
	localparam int PRESS_W   = 32;
	localparam int HUM_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CAL    = 3'd0,
		REG_PRESS_CAL_A = 3'd1,
		REG_PRESS_CAL_B = 3'd2,
		REG_PRESS_CAL_C = 3'd3,
		REG_HUM_CAL_A   = 3'd4,
		REG_HUM_CAL_B   = 3'd5
	} reg_idx_t;

endpackage

@@ rtl/esc_if.sv @@
// Valid/ready stream interfaces for raw samples and compensated results.
// Depends on esc_pkg.
interface esc_sample_if;
	import esc_pkg::*;
	logic               valid;
	logic               ready;
	logic [RAW_P_W-1:0] adc_pressure;
	logic [RAW_T_W-1:0] raw_temperature;
	logic [RAW_H_W-1:0] adc_humidity;
	modport source (output valid, adc_pressure, raw_temperature, adc_humidity, input ready);
	modport sink   (input valid, adc_pressure, raw_temperature, adc_humidity, output ready);
endinterface

interface esc_result_if;
	import esc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [PRESS_W-1:0]       pressure_q24_8;
	logic                     pressure_valid;
	logic [HUM_W-1:0]         humidity_q22_10;
	modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
		humidity_q22_10, input ready);
	modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_valid,
		humidity_q22_10, output ready);
endinterface

@@ rtl/environmental_sensor_compensation_unit.sv @@
// Top level: fixed-point temperature, pressure and humidity compensation pipeline.
// Depends on esc_pkg and the stream interfaces in esc_if.sv.

// One raw sample enters per cycle while the pipeline is not stalled, and its
// compensated result passes 12 stages of fine temperature, temperature, humidity
// and pressure set-up, 64 stages of a bit-per-stage restoring divider that
// produces the pressure quotient, and 5 stages of pressure finishing, the last
// of which is the output register. The whole pipeline advances as one while the
// output register is empty or being taken, so a stall holds every stage in place.
// Calibration is to be written through the plain write port only while the
// block is idle; the block does not enforce it. An index beyond the last register
// is ignored. A zero pressure divisor gives pressure 0 with pressure_valid low.
module environmental_sensor_compensation_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	esc_sample_if.sink                      samples,
	esc_result_if.source                    results,
	input  logic                            wr_en,
	input  logic [esc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [esc_pkg::CFG_DAT_W-1:0]   wr_data
);
	import esc_pkg::*;

	localparam int PRE_ST  = 12;
	localparam int DIV_ST  = 64;
	localparam int POST_ST = 5;
	localparam int NST     = PRE_ST + DIV_ST + POST_ST;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	// calibration registers
	logic [47:0] temp_cal_q;
	logic [63:0] press_cal_a_q, press_cal_b_q;
	logic [15:0] press_cal_c_q;
	logic [31:0] hum_cal_a_q, hum_cal_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
			hum_cal_a_q   <= '0;
			hum_cal_b_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TEMP_CAL:    temp_cal_q    <= wr_data[47:0];
				REG_PRESS_CAL_A: press_cal_a_q <= wr_data;
				REG_PRESS_CAL_B: press_cal_b_q <= wr_data;
				REG_PRESS_CAL_C: press_cal_c_q <= wr_data[15:0];
				REG_HUM_CAL_A:   hum_cal_a_q   <= wr_data[31:0];
				REG_HUM_CAL_B:   hum_cal_b_q   <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// calibration words, sign- or zero-extended to the width their arithmetic needs
	logic [31:0] t1, t2, t3;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;

	always_comb begin
		t1 = {16'd0, temp_cal_q[15:0]};
		t2 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
		t3 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
		p1 = {48'd0, press_cal_a_q[15:0]};
		p2 = {{48{press_cal_a_q[31]}}, press_cal_a_q[31:16]};
		p3 = {{48{press_cal_a_q[47]}}, press_cal_a_q[47:32]};
		p4 = {{48{press_cal_a_q[63]}}, press_cal_a_q[63:48]};
		p5 = {{48{press_cal_b_q[15]}}, press_cal_b_q[15:0]};
		p6 = {{48{press_cal_b_q[31]}}, press_cal_b_q[31:16]};
		p7 = {{48{press_cal_b_q[47]}}, press_cal_b_q[47:32]};
		p8 = {{48{press_cal_b_q[63]}}, press_cal_b_q[63:48]};
		p9 = {{48{press_cal_c_q[15]}}, press_cal_c_q};
		h1 = {24'd0, hum_cal_a_q[7:0]};
		h2 = {{16{hum_cal_a_q[23]}}, hum_cal_a_q[23:8]};
		h3 = {24'd0, hum_cal_a_q[31:24]};
		h4 = {{20{hum_cal_b_q[11]}}, hum_cal_b_q[11:0]};
		h5 = {{20{hum_cal_b_q[23]}}, hum_cal_b_q[23:12]};
		h6 = {{24{hum_cal_b_q[31]}}, hum_cal_b_q[31:24]};
	end

	// pipeline control: every stage advances together
	logic           en;
	logic [NST-1:0] vld_q;

	assign en            = !vld_q[NST-1] || results.ready;
	assign samples.ready = en;
	assign results.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], samples.valid};
		end
	end

	// ---------------- set-up stages ----------------
	logic [RAW_P_W-1:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9;
	logic [RAW_H_W-1:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5, rh_s6;
	logic [31:0] ta_s1, td_s1, m1_s2, m2_s2, v1t_s3, m3_s3, tf_s4;
	logic signed [TEMP_W-1:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;
	logic signed [33:0] pv1_s5;
	logic [31:0] hv_s5;
	logic [63:0] sq_s6, v2a_s7, v1a_s7, v2_s8, v1b_s8, v2_s9, v1c_s9;
	logic [49:0] m5_s6, m2_s6, m5_s7, m2_s7;
	logic [31:0] x1_s6, y1_s6, y2_s6, ha_s7, y3_s7, ha_s8, hm_s8, hv_s9, hv_s10, ss_s10;
	logic [31:0] hv_s11, mh_s11;
	logic [30:0] dv_s10, dv_s11;
	logic [63:0] num0_s10, num_s11;
	logic [HUM_W-1:0] hr_s12;

	// combinational helpers between stages
	logic signed [35:0] t5, tsh;
	logic signed [67:0] sqf;
	logic [63:0] m5x, m2x;
	logic [31:0] hb1, hb, hs, hvv;
	logic [20:0] pbase;

	always_comb begin
		t5    = $signed({{4{tf_s4[31]}}, tf_s4}) * 36'sd5 + 36'sd128;
		tsh   = t5 >>> 8;
		sqf   = pv1_s5 * pv1_s5;
		m5x   = {{14{m5_s7[49]}}, m5_s7};
		m2x   = {{14{m2_s7[49]}}, m2_s7};
		hb1   = asr32(y3_s7, 10) + 32'd2097152;
		hb    = asr32(hm_s8 + 32'd8192, 14);
		hs    = asr32(hv_s9, 15);
		hvv   = hv_s11 - asr32(mh_s11, 4);
		pbase = 21'd1048576 - {1'b0, rp_s9};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// S1: offsets against T1
			rp_s1 <= samples.adc_pressure;
			rh_s1 <= samples.adc_humidity;
			ta_s1 <= {15'd0, samples.raw_temperature[19:3]} - {t1[30:0], 1'b0};
			td_s1 <= {16'd0, samples.raw_temperature[19:4]} - t1;
			// S2
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;
			m1_s2 <= ta_s1 * t2;
			m2_s2 <= td_s1 * td_s1;
			// S3
			rp_s3  <= rp_s2;
			rh_s3  <= rh_s2;
			v1t_s3 <= asr32(m1_s2, 11);
			m3_s3  <= asr32(m2_s2, 12) * t3;
			// S4: fine temperature
			rp_s4 <= rp_s3;
			rh_s4 <= rh_s3;
			tf_s4 <= v1t_s3 + asr32(m3_s3, 14);
			// S5: temperature out, pressure and humidity offsets
			rp_s5 <= rp_s4;
			rh_s5 <= rh_s4;
			if (tsh < -36'sd32768)     tc_s5 <= -16'sd32768;
			else if (tsh > 36'sd32767) tc_s5 <= 16'sd32767;
			else                       tc_s5 <= tsh[15:0];
			pv1_s5 <= $signed({{2{tf_s4[31]}}, tf_s4}) - 34'sd128000;
			hv_s5  <= tf_s4 - 32'd76800;
			// S6
			rp_s6  <= rp_s5;
			rh_s6  <= rh_s5;
			tc_s6  <= tc_s5;
			sq_s6  <= sqf[63:0];
			m5_s6  <= pv1_s5 * $signed(p5[15:0]);
			m2_s6  <= pv1_s5 * $signed(p2[15:0]);
			x1_s6  <= h5 * hv_s5;
			y1_s6  <= hv_s5 * h6;
			y2_s6  <= hv_s5 * h3;
			// S7
			rp_s7  <= rp_s6;
			tc_s7  <= tc_s6;
			v2a_s7 <= sq_s6 * p6;
			v1a_s7 <= sq_s6 * p3;
			m5_s7  <= m5_s6;
			m2_s7  <= m2_s6;
			ha_s7  <= asr32(({16'd0, rh_s6} << 14) - (h4 << 20) - x1_s6 + 32'd16384, 15);
			y3_s7  <= asr32(y1_s6, 10) * (asr32(y2_s6, 11) + 32'd32768);
			// S8
			rp_s8  <= rp_s7;
			tc_s8  <= tc_s7;
			v2_s8  <= v2a_s7 + (m5x << 17) + (p4 << 35);
			v1b_s8 <= asr64(v1a_s7, 8) + (m2x << 12);
			ha_s8  <= ha_s7;
			hm_s8  <= hb1 * h2;
			// S9
			rp_s9  <= rp_s8;
			tc_s9  <= tc_s8;
			v2_s9  <= v2_s8;
			v1c_s9 <= (64'h0000_8000_0000_0000 + v1b_s8) * p1;
			hv_s9  <= ha_s8 * hb;
			// S10: divisor and dividend base
			tc_s10   <= tc_s9;
			dv_s10   <= v1c_s9[63:33];
			num0_s10 <= {12'd0, pbase, 31'd0} - v2_s9;
			hv_s10   <= hv_s9;
			ss_s10   <= hs * hs;
			// S11
			tc_s11  <= tc_s10;
			dv_s11  <= dv_s10;
			num_s11 <= num0_s10 * 64'd3125;
			hv_s11  <= hv_s10;
			mh_s11  <= asr32(ss_s10, 7) * h1;
			// S12: humidity clamp
			tc_s12 <= tc_s11;
			if (hvv[31])                  hr_s12 <= '0;
			else if (hvv > 32'd419430400) hr_s12 <= HUM_W'(32'd419430400 >> 12);
			else                          hr_s12 <= hvv[28:12];
		end
	end

	// S12 feeds the divider with magnitudes and the quotient sign
	typedef struct packed {
		logic [63:0]              q;
		logic [31:0]              rem;
		logic [30:0]              ub;
		logic                     neg;
		logic                     ok;
		logic signed [TEMP_W-1:0] tc;
		logic [HUM_W-1:0]         hr;
	} div_stage_t;

	div_stage_t  div_s     [DIV_ST+1];
	div_stage_t  div_nxt   [DIV_ST];
	logic [32:0] div_trial [DIV_ST];
	logic        div_ge    [DIV_ST];
	div_stage_t  div_head;

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].q   <= num_s11[63] ? (64'd0 - num_s11) : num_s11;
			div_s[0].rem <= '0;
			div_s[0].ub  <= dv_s11[30] ? (31'd0 - dv_s11) : dv_s11;
			div_s[0].neg <= num_s11[63] ^ dv_s11[30];
			div_s[0].ok  <= (dv_s11 != '0);
			div_s[0].tc  <= tc_s11;
			div_s[0].hr  <= '0;
			// divider: one quotient bit per stage
			for (int k = 0; k < DIV_ST; k++) begin
				div_s[k+1] <= div_nxt[k];
			end
		end
	end

	// temperature and humidity are registered in S12 beside the divider head
	always_comb begin
		div_head    = div_s[0];
		div_head.hr = hr_s12;
		div_head.tc = tc_s12;
	end

	always_comb begin
		for (int k = 0; k < DIV_ST; k++) begin
			div_nxt[k]     = (k == 0) ? div_head : div_s[k];
			div_trial[k]   = {div_nxt[k].rem, div_nxt[k].q[63]};
			div_ge[k]      = (div_trial[k] >= {2'b00, div_nxt[k].ub});
			div_nxt[k].q   = {div_nxt[k].q[62:0], div_ge[k]};
			div_nxt[k].rem = div_ge[k] ? 32'(div_trial[k] - {2'b00, div_nxt[k].ub})
				: div_trial[k][31:0];
		end
	end

	// ---------------- pressure finishing ----------------
	logic [63:0] p_q0, p_q1, h_q1, m9_q1, m8_q1, p_q2, pl_q2, m8_q2, sum_q3;
	logic [31:0] c1_q2, c2_q2;
	logic        ok_q0, ok_q1, ok_q2, ok_q3;
	logic signed [TEMP_W-1:0] tc_q0, tc_q1, tc_q2, tc_q3, tc_q4;
	logic [HUM_W-1:0] hr_q0, hr_q1, hr_q2, hr_q3, hr_q4;
	logic [PRESS_W-1:0] pr_q4;
	logic               pok_q4;

	logic [63:0] hsh, prod, pfin;
	div_stage_t  dlast;

	always_comb begin
		dlast = div_s[DIV_ST];
		hsh   = asr64(p_q0, 13);
		prod  = pl_q2 + {c1_q2 + c2_q2, 32'd0};
		pfin  = asr64(sum_q3, 8) + (p7 << 4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Q0: restore quotient sign
			p_q0  <= dlast.neg ? (64'd0 - dlast.q) : dlast.q;
			ok_q0 <= dlast.ok;
			tc_q0 <= dlast.tc;
			hr_q0 <= dlast.hr;
			// Q1
			p_q1  <= p_q0;
			h_q1  <= hsh;
			m9_q1 <= p9 * hsh;
			m8_q1 <= p8 * p_q0;
			ok_q1 <= ok_q0;
			tc_q1 <= tc_q0;
			hr_q1 <= hr_q0;
			// Q2: low 64 bits of the wide product in partial products
			p_q2  <= p_q1;
			pl_q2 <= {32'd0, m9_q1[31:0]} * {32'd0, h_q1[31:0]};
			c1_q2 <= m9_q1[31:0] * h_q1[63:32];
			c2_q2 <= m9_q1[63:32] * h_q1[31:0];
			m8_q2 <= m8_q1;
			ok_q2 <= ok_q1;
			tc_q2 <= tc_q1;
			hr_q2 <= hr_q1;
			// Q3
			sum_q3 <= p_q2 + asr64(prod, 25) + asr64(m8_q2, 19);
			ok_q3  <= ok_q2;
			tc_q3  <= tc_q2;
			hr_q3  <= hr_q2;
			// Q4: output register, saturate to 32 bits
			tc_q4  <= tc_q3;
			hr_q4  <= hr_q3;
			pok_q4 <= ok_q3;
			priority if (!ok_q3)          pr_q4 <= '0;
			else if (pfin[63])            pr_q4 <= '0;
			else if (pfin[62:32] != '0)   pr_q4 <= '1;
			else                          pr_q4 <= pfin[31:0];
		end
	end

	assign results.temperature_centi = tc_q4;
	assign results.pressure_q24_8    = pr_q4;
	assign results.pressure_valid    = pok_q4;
	assign results.humidity_q22_10   = hr_q4;

endmodule
